/* hw/rtl/kch_pkg.sv */
// Shared types, constants and helper functions of the k-mer count histogram.
package kch_pkg;

   localparam int MAX_K      = 8;
   localparam int WIN_W      = 2 * MAX_K;
   localparam int HIST_DEPTH = 1 << WIN_W;
   localparam int RUN_W      = 4;
   localparam int K_W        = 4;
   localparam int CNT_W      = 32;
   localparam int IDX_W      = 16;
   localparam int Q_DEPTH    = 4;
   localparam int Q_PTR_W    = $clog2(Q_DEPTH);
   localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

   localparam logic [K_W-1:0]   K_RESET = K_W'(4);
   localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};

   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_C     = 8'h43;
   localparam logic [7:0] CHAR_G     = 8'h47;
   localparam logic [7:0] CHAR_T     = 8'h54;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;
   localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
   localparam logic [7:0] CASE_DIFF  = 8'h20;

   localparam logic [1:0] CODE_A = 2'd0;
   localparam logic [1:0] CODE_C = 2'd1;
   localparam logic [1:0] CODE_G = 2'd2;
   localparam logic [1:0] CODE_T = 2'd3;

   // What the back end has to do with one queued transaction.
   typedef enum logic [1:0] {
      OP_NONE,
      OP_READ,
      OP_INCR
   } kch_op_type;

   typedef struct packed {
      kch_op_type       op;
      logic [WIN_W-1:0] addr;
   } kch_job_type;

   // Returns {valid, code} for one ASCII byte after case folding.
   function automatic logic [2:0] base_lookup(input logic [7:0] ch);
      logic [7:0] up;
      logic [2:0] res;
      begin
         up = ((ch >= CHAR_LOW_A) && (ch <= CHAR_LOW_Z)) ? (ch - CASE_DIFF) : ch;
         case (up)
            CHAR_A:  res = {1'b1, CODE_A};
            CHAR_C:  res = {1'b1, CODE_C};
            CHAR_G:  res = {1'b1, CODE_G};
            CHAR_T:  res = {1'b1, CODE_T};
            default: res = 3'b000;
         endcase
         return res;
      end
   endfunction

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_SAT) ? CNT_SAT : (v + CNT_W'(1));
   endfunction

endpackage

/* hw/rtl/kch_front.sv */
// Front end: holds k, the rolling base window and run length, and classifies transactions.
module kch_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [kch_pkg::K_W-1:0]    csr_wdata,
   input  logic                       accept,
   input  logic                       req_type,
   input  logic [7:0]                 base_char,
   input  logic                       sequence_start,
   input  logic [kch_pkg::IDX_W-1:0]  count_index,
   output kch_pkg::kch_job_type       job
);

   logic [kch_pkg::K_W-1:0]   kmer_length_ff;
   logic [kch_pkg::WIN_W-1:0] window_ff, window_in, base_win, mask;
   logic [kch_pkg::RUN_W-1:0] run_ff, run_in, base_run, run_next;
   logic [kch_pkg::K_W-1:0]   k_eff;
   logic [kch_pkg::WIN_W:0]   mask_full;
   logic [2:0]                lookup;
   logic                      counted;

   always_comb begin
      priority if (kmer_length_ff == '0) begin
         k_eff = kch_pkg::K_W'(1);
      end else if (kmer_length_ff > kch_pkg::K_W'(kch_pkg::MAX_K)) begin
         k_eff = kch_pkg::K_W'(kch_pkg::MAX_K);
      end else begin
         k_eff = kmer_length_ff;
      end
   end

   assign mask_full = ({{kch_pkg::WIN_W{1'b0}}, 1'b1} << {k_eff, 1'b0})
                      - {{kch_pkg::WIN_W{1'b0}}, 1'b1};
   assign mask      = mask_full[kch_pkg::WIN_W-1:0];

   assign lookup   = kch_pkg::base_lookup(base_char);
   assign base_win = sequence_start ? '0 : window_ff;
   assign base_run = sequence_start ? '0 : run_ff;
   assign run_next = (base_run < kch_pkg::RUN_W'(kch_pkg::MAX_K))
                     ? (base_run + kch_pkg::RUN_W'(1)) : base_run;

   always_comb begin
      window_in = window_ff;
      run_in    = run_ff;
      counted   = 1'b0;
      if (!req_type) begin
         if (lookup[2]) begin
            window_in = (base_win << 2) | kch_pkg::WIN_W'(lookup[1:0]);
            run_in    = run_next;
            counted   = (run_next >= kch_pkg::RUN_W'(k_eff));
         end else begin
            window_in = '0;
            run_in    = '0;
         end
      end
   end

   always_comb begin
      if (req_type) begin
         job.op   = kch_pkg::OP_READ;
         job.addr = count_index;
      end else if (counted) begin
         job.op   = kch_pkg::OP_INCR;
         job.addr = window_in & mask;
      end else begin
         job.op   = kch_pkg::OP_NONE;
         job.addr = window_in & mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kmer_length_ff <= kch_pkg::K_RESET;
         window_ff      <= '0;
         run_ff         <= '0;
      end else begin
         if (csr_we) begin
            kmer_length_ff <= csr_wdata;
         end
         if (accept) begin
            window_ff <= window_in;
            run_ff    <= run_in;
         end
      end
   end

endmodule

/* hw/rtl/kch_queue.sv */
// Short queue of classified jobs between the front end and the histogram back end.
module kch_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  kch_pkg::kch_job_type  push_job,
   input  logic                  pop,
   output kch_pkg::kch_job_type  pop_job,
   output logic                  full,
   output logic                  not_empty
);

   kch_pkg::kch_job_type             slot_ff [kch_pkg::Q_DEPTH];
   logic [kch_pkg::Q_PTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [kch_pkg::Q_CNT_W-1:0]      count_ff, count_in;

   assign full      = (count_ff == kch_pkg::Q_CNT_W'(kch_pkg::Q_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_job   = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + kch_pkg::Q_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - kch_pkg::Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + kch_pkg::Q_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + kch_pkg::Q_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !(push && !pop))
      else $error("job queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !not_empty |-> !pop)
      else $error("job queue read while empty");

endmodule

/* hw/rtl/kch_back.sv */
// Back end: histogram memory with clearing pass, read-modify-write, total and result register.
module kch_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  kch_pkg::kch_job_type        q_job,
   output logic                        pop,
   output logic                        busy,
   input  logic                        rsp_tready,
   output logic                        rsp_tvalid,
   output logic [2*kch_pkg::CNT_W-1:0] rsp_tdata,
   output logic                        rsp_tuser
);

   logic [kch_pkg::CNT_W-1:0] hist_mem [kch_pkg::HIST_DEPTH];

   logic                      clr_busy_ff;
   logic [kch_pkg::WIN_W-1:0] clr_addr_ff;

   logic                      s1_valid_ff;
   kch_pkg::kch_job_type      s1_job_ff;
   logic [kch_pkg::CNT_W-1:0] rdata_ff;

   logic                      wr_valid_ff;
   logic [kch_pkg::WIN_W-1:0] wr_addr_ff;
   logic [kch_pkg::CNT_W-1:0] wr_data_ff;

   logic [kch_pkg::CNT_W-1:0] total_ff, total_inc;

   logic                      out_valid_ff;
   logic [kch_pkg::CNT_W-1:0] out_count_ff, out_total_ff;
   logic                      out_counted_ff;

   logic                      s1_adv, do_incr, mem_we;
   logic [kch_pkg::CNT_W-1:0] old_val, new_val, res_count, mem_wdata;
   logic [kch_pkg::WIN_W-1:0] mem_waddr;

   assign busy   = clr_busy_ff;
   assign s1_adv = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign pop    = q_valid && !clr_busy_ff && (!s1_valid_ff || s1_adv);

   // The most recent increment is forwarded; otherwise the memory already holds it.
   assign old_val   = (wr_valid_ff && (wr_addr_ff == s1_job_ff.addr)) ? wr_data_ff : rdata_ff;
   assign new_val   = kch_pkg::sat_inc(old_val);
   assign total_inc = kch_pkg::sat_inc(total_ff);
   assign do_incr   = s1_adv && (s1_job_ff.op == kch_pkg::OP_INCR);

   always_comb begin
      unique case (s1_job_ff.op)
         kch_pkg::OP_READ: res_count = old_val;
         kch_pkg::OP_INCR: res_count = new_val;
         default:          res_count = '0;
      endcase
   end

   assign mem_we    = clr_busy_ff || do_incr;
   assign mem_waddr = clr_busy_ff ? clr_addr_ff : s1_job_ff.addr;
   assign mem_wdata = clr_busy_ff ? '0 : new_val;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[mem_waddr] <= mem_wdata;
      end
      if (pop) begin
         rdata_ff <= hist_mem[q_job.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         wr_valid_ff  <= 1'b0;
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (clr_busy_ff) begin
            clr_addr_ff <= clr_addr_ff + kch_pkg::WIN_W'(1);
            if (clr_addr_ff == {kch_pkg::WIN_W{1'b1}}) begin
               clr_busy_ff <= 1'b0;
            end
         end
         if (pop) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (do_incr) begin
            wr_valid_ff <= 1'b1;
            total_ff    <= total_inc;
         end
         if (s1_adv) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_job_ff <= q_job;
      end
      if (do_incr) begin
         wr_addr_ff <= s1_job_ff.addr;
         wr_data_ff <= new_val;
      end
      if (s1_adv) begin
         out_count_ff   <= res_count;
         out_total_ff   <= (s1_job_ff.op == kch_pkg::OP_INCR) ? total_inc : total_ff;
         out_counted_ff <= (s1_job_ff.op == kch_pkg::OP_INCR);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_total_ff, out_count_ff};
   assign rsp_tuser  = out_counted_ff;

   a_no_work_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> (!pop && !s1_valid_ff && !do_incr))
      else $error("histogram access during clearing pass");

   a_total_monotonic: assert property (@(posedge clock) disable iff (reset)
      !clr_busy_ff |=> (total_ff >= $past(total_ff)))
      else $error("window total decreased");

   a_stalled_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(s1_job_ff) && $stable(rdata_ff)))
      else $error("read-modify-write stage lost its job while stalled");

   a_result_matches_total: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> (out_total_ff == total_ff))
      else $error("result total disagrees with running total");

endmodule

/* hw/rtl/kmer_count_histogram.sv */
// Top level of the k-mer count histogram: front end, job queue and histogram back end.
//
//  Channel  Direction  Handshake              Payload
//  req_     in         req_tvalid/req_tready  tdata: base_char, sequence_start, count_index
//                                             tuser: req_type
//  rsp_     out        rsp_tvalid/rsp_tready  tdata: count_value, total_windows
//                                             tuser: window_counted
//  csr_     in         csr_we                 csr_wdata: kmer_length
//
// One transaction per cycle is accepted while the job queue has room; its result passes
// through the queue slot, the job register with memory read, then read-modify-write into
// the result register; forwarding of the last increment keeps one per cycle unless rsp_
// stalls. After reset a clearing pass zeroes the 65536 histogram entries, with req_tready
// low meanwhile; csr writes are taken as ever. A stall on rsp_ holds the result register,
// then the read-modify-write stage, while the queue takes transactions until full.
module kmer_count_histogram (
   input  logic                         clock,
   input  logic                         reset,
   // Configuration: csr_wdata holds kmer_length.
   input  logic                         csr_we,
   input  logic [kch_pkg::K_W-1:0]      csr_wdata,
   // Requests.
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [31:0]                  req_tdata,   // [7:0] base_char, [8] sequence_start,
                                                     // [24:9] count_index, [31:25] zero
   input  logic                         req_tuser,   // [0] req_type
   // Results.
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [2*kch_pkg::CNT_W-1:0]  rsp_tdata,   // [31:0] count_value,
                                                     // [63:32] total_windows
   output logic                         rsp_tuser    // [0] window_counted
);

   // Field unpacking of the request transaction.
   logic [7:0]                base_char;
   logic                      sequence_start;
   logic [kch_pkg::IDX_W-1:0] count_index;

   assign base_char      = req_tdata[7:0];
   assign sequence_start = req_tdata[8];
   assign count_index    = req_tdata[24:9];

   kch_pkg::kch_job_type front_job, queue_job;
   logic                 accept, q_full, q_not_empty, q_pop, back_busy;

   // The queue decouples acceptance from the histogram side; it does not depend on rsp_tready.
   assign req_tready = !q_full && !back_busy;
   assign accept     = req_tvalid && req_tready;

   kch_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .accept         (accept),
      .req_type       (req_tuser),
      .base_char      (base_char),
      .sequence_start (sequence_start),
      .count_index    (count_index),
      .job            (front_job)
   );

   kch_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_job  (front_job),
      .pop       (q_pop),
      .pop_job   (queue_job),
      .full      (q_full),
      .not_empty (q_not_empty)
   );

   kch_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_not_empty),
      .q_job      (queue_job),
      .pop        (q_pop),
      .busy       (back_busy),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
